// ===== hw/rtl/imm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the int8 matrix multiply core.
package imm_pkg;

   // Item kinds carried on the request tuser bit
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ACT  = 1'b1;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_ROWS     = 2'd0;
   localparam logic [1:0] REG_KGROUPS  = 2'd1;
   localparam logic [1:0] REG_COLUMNS  = 2'd2;

   localparam int LANE_FIELDS = 4;
   localparam int LANE_IDX_W  = 2;
   localparam int LANE_W      = 8;
   localparam int PROD_W      = 16;
   localparam int SUM_W       = 26;

   localparam int IN_ROW_W    = 4;
   localparam int IN_GROUP_W  = 8;
   localparam int OUT_ROW_W   = 4;
   localparam int COL_W       = 12;
   localparam int COL_CNT_W   = 13;
   localparam int MAX_COLUMNS = 4096;

   localparam int ROWS_REG_W    = 5;
   localparam int KGROUPS_REG_W = 9;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Controller to datapath commands
   typedef struct packed {
      logic load_weight;
      logic act_capture;
      logic mac_issue;
      logic out_read;
      logic out_load;
      logic out_last;
      logic clear_acc;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
      logic pipe_busy;
   } status_type;

endpackage

// ===== hw/rtl/imm_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine with the row, group and column counters.
module imm_ctrl #(
   parameter int MAX_ROWS     = 16,
   parameter int MAX_K_GROUPS = 256,
   localparam int ROW_W  = $clog2(MAX_ROWS),
   localparam int RCNT_W = $clog2(MAX_ROWS + 1),
   localparam int GRP_W  = (MAX_K_GROUPS > 1) ? $clog2(MAX_K_GROUPS) : 1,
   localparam int GCNT_W = $clog2(MAX_K_GROUPS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_opcode,
   output logic                       req_tready,
   input  logic [RCNT_W-1:0]          rows_in_use,
   input  logic [GCNT_W-1:0]          k_groups_in_use,
   input  logic [imm_pkg::COL_CNT_W-1:0] columns_in_use,
   input  imm_pkg::status_type        status,
   output imm_pkg::cmd_type           cmd,
   output logic [ROW_W-1:0]           row_idx,
   output logic [GRP_W-1:0]           group_idx,
   output logic [imm_pkg::COL_W-1:0]  column_idx
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_OUT_READ,
      ST_OUT_LOAD
   } state_type;

   state_type                      state_ff, state_in;
   logic [ROW_W-1:0]               row_ff, row_in;
   logic [GCNT_W-1:0]              group_ff, group_in;
   logic [imm_pkg::COL_W-1:0]      column_ff, column_in;
   logic [GCNT_W-1:0]              group_inc;
   logic [imm_pkg::COL_CNT_W-1:0]  column_inc;
   logic                           accept;
   logic                           row_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign row_last   = ((RCNT_W'(row_ff) + RCNT_W'(1)) == rows_in_use);
   assign group_inc  = group_ff + GCNT_W'(1);
   assign column_inc = {1'b0, column_ff} + imm_pkg::COL_CNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      group_in  = group_ff;
      column_in = column_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == imm_pkg::OP_ACT) begin
                  cmd.act_capture = 1'b1;
                  row_in          = '0;
                  state_in        = ST_MAC;
               end else begin
                  cmd.load_weight = 1'b1;
               end
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            if (row_last) begin
               state_in = ST_DRAIN;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         ST_DRAIN: begin
            // wait for the last row's sum to land before moving on
            if (!status.pipe_busy) begin
               group_in = group_inc;
               row_in   = '0;
               if (group_inc >= k_groups_in_use) begin
                  state_in = ST_OUT_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT_READ: begin
            cmd.out_read = 1'b1;
            state_in     = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = row_last;
               if (row_last) begin
                  cmd.clear_acc = 1'b1;
                  group_in      = '0;
                  if (column_inc >= columns_in_use) begin
                     column_in = '0;
                  end else begin
                     column_in = column_inc[imm_pkg::COL_W-1:0];
                  end
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + ROW_W'(1);
                  state_in = ST_OUT_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         row_ff    <= '0;
         group_ff  <= '0;
         column_ff <= '0;
      end else begin
         state_ff  <= state_in;
         row_ff    <= row_in;
         group_ff  <= group_in;
         column_ff <= column_in;
      end
   end

   assign row_idx    = row_ff;
   assign group_idx  = group_ff[GRP_W-1:0];
   assign column_idx = column_ff;

`ifndef NO_ASSERTIONS
   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      accept |-> !status.pipe_busy)
      else $error("item accepted while the MAC pipeline still holds sums");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over one not yet taken");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (RCNT_W'(row_ff) < rows_in_use))
      else $error("row counter beyond rows in use");
`endif

endmodule

// ===== hw/rtl/imm_datapath.sv =====
`timescale 1ns / 1ps
// Weight store, accumulator store, four-lane MAC pipeline and result register.
module imm_datapath #(
   parameter int MAX_ROWS     = 16,
   parameter int MAX_K_GROUPS = 256,
   parameter int LANES        = 4,
   localparam int ROW_W   = $clog2(MAX_ROWS),
   localparam int GRP_W   = (MAX_K_GROUPS > 1) ? $clog2(MAX_K_GROUPS) : 1,
   localparam int DEPTH   = MAX_ROWS * MAX_K_GROUPS,
   localparam int WADDR_W = $clog2(DEPTH)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  imm_pkg::cmd_type                      cmd,
   output imm_pkg::status_type                   status,
   input  logic [imm_pkg::IN_ROW_W-1:0]          req_row,
   input  logic [imm_pkg::IN_GROUP_W-1:0]        req_group,
   input  logic [imm_pkg::LANE_FIELDS-1:0][imm_pkg::LANE_W-1:0] req_lanes,
   input  logic [ROW_W-1:0]                      row_idx,
   input  logic [GRP_W-1:0]                      group_idx,
   input  logic [imm_pkg::COL_W-1:0]             column_idx,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [imm_pkg::OUT_ROW_W-1:0]         out_row,
   output logic [imm_pkg::COL_W-1:0]             out_column,
   output logic [imm_pkg::SUM_W-1:0]             out_sum,
   output logic                                  out_last
);

   logic [LANES-1:0][imm_pkg::LANE_W-1:0] weight_mem [DEPTH];
   logic [imm_pkg::SUM_W-1:0]             acc_mem [MAX_ROWS];

   logic [MAX_ROWS-1:0]                   acc_vld_ff;
   logic [LANES-1:0][imm_pkg::LANE_W-1:0] lane_word;
   logic [LANES-1:0][imm_pkg::LANE_W-1:0] wt_rd_ff;
   logic [LANES-1:0][imm_pkg::LANE_W-1:0] act_ff;
   logic                                  load_ok;
   logic [WADDR_W-1:0]                    load_addr;
   logic [WADDR_W-1:0]                    mac_addr;
   logic [imm_pkg::SUM_W-1:0]             acc_rd_ff;
   logic                                  acc_rd_vld_ff;
   logic                                  s1_valid_ff;
   logic [ROW_W-1:0]                      s1_row_ff;
   logic                                  s2_valid_ff;
   logic [ROW_W-1:0]                      s2_row_ff;
   logic [LANES-1:0][imm_pkg::PROD_W-1:0] prod_ff;
   logic [imm_pkg::SUM_W-1:0]             s2_acc_ff;
   logic [imm_pkg::SUM_W-1:0]             dot_sum;
   logic [imm_pkg::SUM_W-1:0]             acc_next;
   logic                                  rsp_valid_ff;
   logic [imm_pkg::OUT_ROW_W-1:0]         out_row_ff;
   logic [imm_pkg::COL_W-1:0]             out_column_ff;
   logic [imm_pkg::SUM_W-1:0]             out_sum_ff;
   logic                                  out_last_ff;

   // lanes past the four input fields hold zero
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (i < imm_pkg::LANE_FIELDS) begin
            lane_word[i] = req_lanes[imm_pkg::LANE_IDX_W'(i)];
         end else begin
            lane_word[i] = '0;
         end
      end
   end

   assign load_ok   = (int'(req_row) < MAX_ROWS) && (int'(req_group) < MAX_K_GROUPS);
   assign load_addr = WADDR_W'(int'(req_row) * MAX_K_GROUPS + int'(req_group));
   assign mac_addr  = WADDR_W'(int'(row_idx) * MAX_K_GROUPS + int'(group_idx));

   always_ff @(posedge clock) begin
      if (cmd.load_weight && load_ok) begin
         weight_mem[load_addr] <= lane_word;
      end
      if (cmd.mac_issue) begin
         wt_rd_ff <= weight_mem[mac_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_mem[s2_row_ff] <= acc_next;
      end
      if (cmd.mac_issue || cmd.out_read) begin
         acc_rd_ff <= acc_mem[row_idx];
      end
   end

   always_comb begin
      dot_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         dot_sum = dot_sum + imm_pkg::SUM_W'($signed(prod_ff[i]));
      end
   end

   assign acc_next = s2_acc_ff + dot_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff    <= '0;
         acc_rd_vld_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.mac_issue;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.mac_issue || cmd.out_read) begin
            acc_rd_vld_ff <= acc_vld_ff[row_idx];
         end
         if (cmd.clear_acc) begin
            acc_vld_ff <= '0;
         end else if (s2_valid_ff) begin
            acc_vld_ff[s2_row_ff] <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act_capture) begin
         act_ff <= lane_word;
      end
      s1_row_ff <= row_idx;
      s2_row_ff <= s1_row_ff;
      for (int i = 0; i < LANES; i++) begin
         prod_ff[i] <= imm_pkg::PROD_W'($signed(wt_rd_ff[i]) * $signed(act_ff[i]));
      end
      s2_acc_ff <= acc_rd_vld_ff ? acc_rd_ff : '0;
      if (cmd.out_load) begin
         out_row_ff    <= imm_pkg::OUT_ROW_W'(row_idx);
         out_column_ff <= column_idx;
         out_sum_ff    <= acc_rd_vld_ff ? acc_rd_ff : '0;
         out_last_ff   <= cmd.out_last;
      end
   end

   assign status.out_free  = !rsp_valid_ff || rsp_tready;
   assign status.pipe_busy = s1_valid_ff || s2_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign out_row    = out_row_ff;
   assign out_column = out_column_ff;
   assign out_sum    = out_sum_ff;
   assign out_last   = out_last_ff;

`ifndef NO_ASSERTIONS
   a_no_acc_collision: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && (cmd.mac_issue || cmd.out_read)) |-> (s2_row_ff != row_idx))
      else $error("accumulator read of a row whose sum is still being written");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $past(s1_valid_ff))
      else $error("MAC write stage valid without a preceding product stage");
`endif

endmodule

// ===== hw/rtl/int8_matrix_multiply_core.sv =====
`timescale 1ns / 1ps
// Top level of the int8 matrix multiply core: channels, registers, controller and datapath.
//
// Use: program rows, k groups and columns over the csr_ port while idle, then send
// weight items (tuser 0) that fill the store one (row, k group) word at a time, then
// activation items (tuser 1), four k values of one column of B each, k groups in order.
// Every activation updates each row in use: one weight word read and four lane MACs
// per cycle, and no next item is taken until its rows are issued and the MAC
// pipeline has drained; after a weight item the block is ready again. After the last
// k group of a column the block emits one result item per row in use, rows ascending,
// tlast on the last row, each from an accumulator read and then an output load.
// The accumulators are then cleared and the column counter advances, wrapping at
// columns_in_use. A single output register separates the result side: a stalled
// receiver holds the result there, which halts the result sequence and the input
// with it; once a column's last result sits in the register, items are taken again
// and only the next column end waits for the receiver. Reset clears the counters,
// accumulators and registers (1, 1, 1); the weight store is not cleared and must be
// written before it is used.
module int8_matrix_multiply_core #(
   parameter int MAX_ROWS     = 16,
   parameter int MAX_K_GROUPS = 256,
   parameter int LANES        = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row_index[3:0], group_index[11:4], lane_0[19:12], lane_1[27:20],
   // lane_2[35:28], lane_3[43:36], zero pad[47:44]
   input  logic [imm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode[0]: 0 weight load, 1 activation
   input  logic                              req_tuser,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_row[3:0], out_column[15:4], sum_value[41:16], zero pad[47:42]
   output logic [imm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // last_of_column
   output logic                              rsp_tlast,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [imm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [imm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [imm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int GRP_W  = (MAX_K_GROUPS > 1) ? $clog2(MAX_K_GROUPS) : 1;
   localparam int GCNT_W = $clog2(MAX_K_GROUPS + 1);

   logic [RCNT_W-1:0]              rows_ff, rows_in;
   logic [GCNT_W-1:0]              kgroups_ff, kgroups_in;
   logic [imm_pkg::COL_CNT_W-1:0]  columns_ff, columns_in;
   logic                           csr_write;
   logic [1:0]                     csr_index;
   logic [imm_pkg::ROWS_REG_W-1:0]    rows_wr;
   logic [imm_pkg::KGROUPS_REG_W-1:0] kgroups_wr;
   logic [imm_pkg::COL_CNT_W-1:0]     columns_wr;

   imm_pkg::cmd_type               cmd;
   imm_pkg::status_type            status;
   logic [ROW_W-1:0]               row_idx;
   logic [GRP_W-1:0]               group_idx;
   logic [imm_pkg::COL_W-1:0]      column_idx;
   logic [imm_pkg::OUT_ROW_W-1:0]  out_row;
   logic [imm_pkg::COL_W-1:0]      out_column;
   logic [imm_pkg::SUM_W-1:0]      out_sum;
   logic                           out_last;

   // ---- register port: writes complete in the access phase, never wait ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];
   assign rows_wr    = csr_pwdata[imm_pkg::ROWS_REG_W-1:0];
   assign kgroups_wr = csr_pwdata[imm_pkg::KGROUPS_REG_W-1:0];
   assign columns_wr = csr_pwdata[imm_pkg::COL_CNT_W-1:0];

   // zero reads as one, anything above the maximum as the maximum
   always_comb begin
      rows_in    = rows_ff;
      kgroups_in = kgroups_ff;
      columns_in = columns_ff;
      if (csr_write) begin
         unique case (csr_index)
            imm_pkg::REG_ROWS: begin
               if (rows_wr == '0) begin
                  rows_in = RCNT_W'(1);
               end else if (int'(rows_wr) > MAX_ROWS) begin
                  rows_in = RCNT_W'(MAX_ROWS);
               end else begin
                  rows_in = RCNT_W'(rows_wr);
               end
            end
            imm_pkg::REG_KGROUPS: begin
               if (kgroups_wr == '0) begin
                  kgroups_in = GCNT_W'(1);
               end else if (int'(kgroups_wr) > MAX_K_GROUPS) begin
                  kgroups_in = GCNT_W'(MAX_K_GROUPS);
               end else begin
                  kgroups_in = GCNT_W'(kgroups_wr);
               end
            end
            imm_pkg::REG_COLUMNS: begin
               if (columns_wr == '0) begin
                  columns_in = imm_pkg::COL_CNT_W'(1);
               end else if (int'(columns_wr) > imm_pkg::MAX_COLUMNS) begin
                  columns_in = imm_pkg::COL_CNT_W'(imm_pkg::MAX_COLUMNS);
               end else begin
                  columns_in = columns_wr;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= RCNT_W'(1);
         kgroups_ff <= GCNT_W'(1);
         columns_ff <= imm_pkg::COL_CNT_W'(1);
      end else begin
         rows_ff    <= rows_in;
         kgroups_ff <= kgroups_in;
         columns_ff <= columns_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         imm_pkg::REG_ROWS:    csr_prdata = imm_pkg::CSR_DATA_W'(rows_ff);
         imm_pkg::REG_KGROUPS: csr_prdata = imm_pkg::CSR_DATA_W'(kgroups_ff);
         imm_pkg::REG_COLUMNS: csr_prdata = imm_pkg::CSR_DATA_W'(columns_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // ---- sequencing ----
   imm_ctrl #(
      .MAX_ROWS     (MAX_ROWS),
      .MAX_K_GROUPS (MAX_K_GROUPS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_opcode      (req_tuser),
      .req_tready      (req_tready),
      .rows_in_use     (rows_ff),
      .k_groups_in_use (kgroups_ff),
      .columns_in_use  (columns_ff),
      .status          (status),
      .cmd             (cmd),
      .row_idx         (row_idx),
      .group_idx       (group_idx),
      .column_idx      (column_idx)
   );

   // ---- stores, MAC pipeline and result register ----
   imm_datapath #(
      .MAX_ROWS     (MAX_ROWS),
      .MAX_K_GROUPS (MAX_K_GROUPS),
      .LANES        (LANES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_row    (req_tdata[3:0]),
      .req_group  (req_tdata[11:4]),
      .req_lanes  (req_tdata[43:12]),
      .row_idx    (row_idx),
      .group_idx  (group_idx),
      .column_idx (column_idx),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .out_row    (out_row),
      .out_column (out_column),
      .out_sum    (out_sum),
      .out_last   (out_last)
   );

   assign rsp_tdata = {6'b0, out_sum, out_column, out_row};
   assign rsp_tlast = out_last;

endmodule
